/* rtl/cwt_pkg.sv */
// ----------------------------------------------------------------------------
// CIGAR window trimmer package
// Op codes, shared item structs and op classification functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwt_pkg;

  // CIGAR op codes, BAM numbering.
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  localparam int PosW = 31;
  localparam int LenW = 28;
  localparam int AccW = 32;

  // One input item after the per-read bounds have been worked out.
  typedef struct packed {
    logic            first;
    logic            last;
    logic [3:0]      op;
    logic [LenW-1:0] len;
    logic [PosW-1:0] trim;
    logic [PosW-1:0] win;
    logic            err;
    logic [PosW-1:0] start;
  } prep_t;

  // One result item.
  typedef struct packed {
    logic            unit_valid;
    logic [3:0]      unit_op;
    logic [LenW-1:0] unit_length;
    logic [PosW-1:0] new_position;
    logic [AccW-1:0] seq_offset;
    logic [AccW-1:0] seq_length;
    logic            window_error;
    logic            read_done;
  } result_t;

  function automatic logic adv_ref(input logic [3:0] op);
    logic r;
    case (op) inside
      OP_M, OP_D, OP_N, OP_EQ, OP_X: r = 1'b1;
      default:                       r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic adv_read(input logic [3:0] op);
    logic r;
    case (op) inside
      OP_M, OP_I, OP_S, OP_EQ, OP_X: r = 1'b1;
      default:                       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/cwt_prep.sv */
// ----------------------------------------------------------------------------
// CIGAR window trimmer input stage
// Registers an accepted item together with its left trim and window length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwt_prep (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic                    adv,
  input  wire logic                    first_unit,
  input  wire logic                    last_unit,
  input  wire logic [30:0]             read_position,
  input  wire logic [30:0]             region_start,
  input  wire logic [30:0]             region_end,
  input  wire logic [3:0]              op_code,
  input  wire logic [27:0]             op_length,
  output      logic                    valid,
  output      cwt_pkg::prep_t          item
);

  logic           start_after;
  logic [30:0]    base;
  logic [31:0]    diff;
  cwt_pkg::prep_t item_next;

  always_comb begin
    start_after = region_start > read_position;
    base        = start_after ? region_start : read_position;
    diff        = {1'b0, region_end} - {1'b0, base};
    item_next.first = first_unit;
    item_next.last  = last_unit;
    item_next.op    = op_code;
    item_next.len   = op_length;
    item_next.trim  = start_after ? (region_start - read_position) : '0;
    item_next.win   = diff[30:0];
    // A negative or empty window is an error for the whole read.
    item_next.err   = diff[31] || (diff == '0);
    item_next.start = base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (adv) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cwt_step.sv */
// ----------------------------------------------------------------------------
// CIGAR window trimmer step
// Holds the per-read trimming state and forms one result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwt_step (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire cwt_pkg::prep_t   item,
  output      cwt_pkg::result_t result
);

  logic [30:0] trim_rem, trim_rem_next;
  logic [30:0] win_rem, win_rem_next;
  logic [31:0] offset_accum, offset_accum_next;
  logic [31:0] length_accum, length_accum_next;
  logic [30:0] aligned_start, aligned_start_next;
  logic        finished, finished_next;
  logic        error_seen, error_seen_next;

  logic [30:0] trim_e;
  logic [30:0] win_e;
  logic [31:0] off_e;
  logic [31:0] lacc_e;
  logic        fin_e;
  logic        rf;
  logic        rd;
  logic [27:0] ref_len;
  logic [27:0] cut_len;
  logic [27:0] emit_len;
  logic        in_window;
  logic        in_trim;
  logic [30:0] off_add;
  logic [32:0] off_sum;
  logic [32:0] len_sum;
  logic        valid;

  always_comb begin
    // A first item restarts the read with the bounds worked out upstream.
    if (item.first) begin
      trim_e             = item.err ? '0 : item.trim;
      win_e              = item.err ? '0 : item.win;
      off_e              = '0;
      lacc_e             = '0;
      fin_e              = 1'b0;
      error_seen_next    = item.err;
      aligned_start_next = item.start;
    end else begin
      trim_e             = trim_rem;
      win_e              = win_rem;
      off_e              = offset_accum;
      lacc_e             = length_accum;
      fin_e              = finished;
      error_seen_next    = error_seen;
      aligned_start_next = aligned_start;
    end

    rf      = cwt_pkg::adv_ref(item.op);
    rd      = cwt_pkg::adv_read(item.op);
    ref_len = rf ? item.len : '0;
    in_trim = (trim_e != '0) && ({3'b0, ref_len} <= trim_e);

    // A unit that straddles the trim boundary keeps only its tail.
    if (trim_e != '0 && !in_trim) begin
      cut_len = ref_len - trim_e[27:0];
      off_add = trim_e;
    end else begin
      cut_len = item.len;
      off_add = {3'b0, item.len};
    end

    trim_rem_next     = trim_e;
    win_rem_next      = win_e;
    finished_next     = fin_e;
    offset_accum_next = off_e;
    length_accum_next = lacc_e;
    valid             = 1'b0;
    emit_len          = '0;
    in_window         = 1'b0;
    off_sum           = {1'b0, off_e} + {2'b0, off_add};
    len_sum           = '0;

    if (!error_seen_next && !fin_e) begin
      if (trim_e != '0) begin
        trim_rem_next = in_trim ? (trim_e - {3'b0, ref_len}) : '0;
        if (rd) begin
          offset_accum_next = off_sum[32] ? '1 : off_sum[31:0];
        end
      end
      in_window = !in_trim;
      if (in_window) begin
        valid = 1'b1;
        if ((rf ? {3'b0, cut_len} : '0) <= win_e) begin
          emit_len     = cut_len;
          win_rem_next = win_e - (rf ? {3'b0, cut_len} : '0);
        end else begin
          // Only reached while the remaining window is below one unit length.
          emit_len      = win_e[27:0];
          win_rem_next  = '0;
          finished_next = 1'b1;
        end
        len_sum = {1'b0, lacc_e} + {5'b0, emit_len};
        if (rd) begin
          length_accum_next = len_sum[32] ? '1 : len_sum[31:0];
        end
      end
    end

    result.unit_valid   = valid;
    result.unit_op      = valid ? item.op : '0;
    result.unit_length  = valid ? emit_len : '0;
    result.new_position = error_seen_next ? '0 : aligned_start_next;
    result.seq_offset   = error_seen_next ? '0 : offset_accum_next;
    result.seq_length   = error_seen_next ? '0 : length_accum_next;
    result.window_error = error_seen_next;
    result.read_done    = item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_rem      <= '0;
      win_rem       <= '0;
      offset_accum  <= '0;
      length_accum  <= '0;
      aligned_start <= '0;
      finished      <= 1'b0;
      error_seen    <= 1'b0;
    end else if (step) begin
      trim_rem      <= trim_rem_next;
      win_rem       <= win_rem_next;
      offset_accum  <= offset_accum_next;
      length_accum  <= length_accum_next;
      aligned_start <= aligned_start_next;
      finished      <= finished_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cigar_window_trimmer_core.sv */
// ----------------------------------------------------------------------------
// CIGAR window trimmer
// Trims a read's CIGAR units to a reference window, one unit per item.
// ----------------------------------------------------------------------------
// Usage: CIGAR units enter on the s_ stream, one item per unit. The item that
// starts a read has s_tuser set and also carries the read position and the
// region bounds; s_tlast marks the read's final unit. Every input item gives
// exactly one result item on the m_ stream: the kept unit (m_tuser bit 0
// says whether one is emitted), the new alignment start and the running
// sequence offset and length, with the window error flag in m_tuser bit 1.
// From acceptance to m_tvalid an item passes one input register that
// works out the left trim and window length, then the state update feeding
// the result register. Throughput is one item per cycle while the receiver
// does not stall, as the trimming state updates once per item. Reset clears
// the pipeline and the read state; units arriving before any first unit see
// an empty window. When the receiver stalls the result register holds, the
// input register fills, and then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cigar_window_trimmer_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // read_position[30:0], region_start[61:31], region_end[92:62],
  // op_code[96:93], op_length[124:97], zero fill above
  input  wire logic [127:0] s_tdata,
  input  wire logic         s_tuser,  // first_unit
  input  wire logic         s_tlast,  // last_unit
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // unit_op[3:0], unit_length[31:4], new_position[62:32],
  // seq_offset[94:63], seq_length[126:95], zero fill above
  output      logic [127:0] m_tdata,
  output      logic [1:0]   m_tuser,  // unit_valid[0], window_error[1]
  output      logic         m_tlast   // read_done
);

  logic             s1_valid;
  logic             s1_adv;
  logic             load;
  cwt_pkg::prep_t   s1_item;
  cwt_pkg::result_t step_res;
  cwt_pkg::result_t out_res;
  logic             out_valid;

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || !out_valid || m_tready;
  assign load     = s_tvalid && s_tready;

  cwt_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .adv           (s1_adv),
    .first_unit    (s_tuser),
    .last_unit     (s_tlast),
    .read_position (s_tdata[30:0]),
    .region_start  (s_tdata[61:31]),
    .region_end    (s_tdata[92:62]),
    .op_code       (s_tdata[96:93]),
    .op_length     (s_tdata[124:97]),
    .valid         (s1_valid),
    .item          (s1_item)
  );

  cwt_step u_step (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .item   (s1_item),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.seq_length, out_res.seq_offset,
                     out_res.new_position, out_res.unit_length, out_res.unit_op};
  assign m_tuser  = {out_res.window_error, out_res.unit_valid};
  assign m_tlast  = out_res.read_done;

  // A read with a bad window never emits a unit.
  a_err_no_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata[126:32] == '0)
    else $error("unit emitted under window error");

  // Units that are not emitted carry no op or length.
  a_idle_unit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == '0)
    else $error("suppressed unit carries op or length");

  // An item in the input register is not dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input register lost an item");

  // The result register and its data hold while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(m_tdata))
    else $error("result register changed while stalled");

endmodule

`default_nettype wire
